[sv/integer_to_ascii_formatter_unit_assert.svh]
// Assertion macros for the integer to ASCII formatter checker.
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("formatter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("formatter assertion failed");

`endif

[sv/itaf_pkg.sv]
// Shared constants and the digit-to-character function of the formatter.
`default_nettype none
package itaf_pkg;

	// kind selector codes
	localparam logic [1:0] KIND_SDEC = 2'd0;
	localparam logic [1:0] KIND_UDEC = 2'd1;
	localparam logic [1:0] KIND_LHEX = 2'd2;
	localparam logic [1:0] KIND_UHEX = 2'd3;

	localparam int unsigned MAX_DIGITS = 16;
	localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
	localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_LA    = 8'h61;
	localparam logic [7:0] ASCII_UA    = 8'h41;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_LF    = 8'h66;
	localparam logic [7:0] ASCII_UF    = 8'h46;

	localparam logic [3:0] DEC_BASE = 4'd10;

	// ceil(2^35 / 10): floor(w * RECIP10 / 2^35) == w / 10 for any 32-bit w
	localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SHR = 35;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? ASCII_UA : ASCII_LA;
		if (d < DEC_BASE) begin
			digit_char = ASCII_ZERO + {4'b0, d};
		end else begin
			digit_char = base + {4'b0, d} - {4'b0, DEC_BASE};
		end
	endfunction

endpackage
`default_nettype wire

[sv/integer_to_ascii_formatter_unit.sv]
// Top level: integer to ASCII decimal / hex formatter with a shared digit unit.
//
// Channel  Dir  Signals                              Content
// s_*      in   s_tvalid s_tready s_tdata s_tuser    one number + kind per transaction
// m_*      out  m_tvalid m_tready m_tdata m_tlast    one ASCII character per transaction
//
// Sequence: accept, then per digit either a multiply by 1/10 followed by a fold
//   of quotient and remainder (decimal) or a nibble shift (hex), then one
//   character out per cycle (sign included) while m_tready stays high.
//   The digit loop sets the worst case.
// s_tready is high only while the sequencer is idle; a finished last character
//   may still sit in the output register while the next number is taken.
// m_tready low stalls character emission only; the digit buffer holds.
// Reset (arst_n low) returns the sequencer to idle and drops m_tvalid.
`default_nettype none
module integer_to_ascii_formatter_unit #(
	parameter int unsigned VALUE_BITS = 64 // hex kinds use value[VALUE_BITS-1:0], 32..64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [63:0] value
	input  wire logic [1:0]  s_tuser,   // [1:0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] char_code
	output logic             m_tlast
);

	localparam int unsigned CNT_W = itaf_pkg::CNT_W;
	localparam int unsigned IDX_W = itaf_pkg::IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,   // product of working value and 1/10
		ST_DIV,   // quotient back to work, remainder into digit buffer
		ST_HEX,   // low nibble into digit buffer, shift by 4
		ST_EMIT   // sign, then digits most significant first
	} state_t;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   work_q;
	logic [63:0]             prod_q;
	logic [CNT_W-1:0]        n_q;      // digits stored / digits left to emit
	logic                    neg_q;
	logic                    upper_q;
	logic                    m_tvalid_q;
	logic [7:0]              m_tdata_q;
	logic                    m_tlast_q;
	logic [3:0]              dig_q [itaf_pkg::MAX_DIGITS];

	logic                    is_dec;
	logic                    is_neg;
	logic [31:0]             mag;
	logic [63:0]             prod_d;
	logic [28:0]             quo;
	logic [31:0]             quo10;
	logic [31:0]             rem32;
	logic [CNT_W-1:0]        n_m1;
	logic                    dig_we;
	logic [3:0]              dig_wd;
	logic                    out_free;
	logic                    emit_go;

	assign is_dec = s_tuser inside {itaf_pkg::KIND_SDEC, itaf_pkg::KIND_UDEC};
	assign is_neg = (s_tuser == itaf_pkg::KIND_SDEC) && s_tdata[31];
	assign mag    = is_neg ? ((~s_tdata[31:0]) + 32'd1) : s_tdata[31:0];

	// shared arithmetic: one 32x32 multiply, registered before the fold
	assign prod_d = work_q[31:0] * itaf_pkg::RECIP10;
	assign quo    = prod_q[63:itaf_pkg::RECIP_SHR];
	assign quo10  = {quo, 3'b000} + {2'b00, quo, 1'b0};
	assign rem32  = work_q[31:0] - quo10;

	assign n_m1     = n_q - CNT_W'(1);
	assign out_free = !m_tvalid_q || m_tready;
	assign emit_go  = (state_q == ST_EMIT) && out_free;

	always_comb begin
		dig_we = 1'b0;
		dig_wd = work_q[3:0];
		case (state_q)
			ST_DIV: begin
				dig_we = 1'b1;
				dig_wd = rem32[3:0];
			end
			ST_HEX: begin
				dig_we = 1'b1;
			end
			default: begin
				dig_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dig_we) begin
			dig_q[n_q[IDX_W-1:0]] <= dig_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			work_q     <= '0;
			prod_q     <= '0;
			n_q        <= '0;
			neg_q      <= 1'b0;
			upper_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			// a new character replaces the one taken in the same cycle
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						n_q     <= '0;
						upper_q <= (s_tuser == itaf_pkg::KIND_UHEX);
						neg_q   <= is_neg;
						if (is_dec) begin
							work_q  <= VALUE_BITS'(mag);
							state_q <= ST_MUL;
						end else begin
							work_q  <= s_tdata[VALUE_BITS-1:0];
							state_q <= ST_HEX;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= prod_d;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					n_q    <= n_q + CNT_W'(1);
					work_q <= VALUE_BITS'(quo);
					if (quo == '0) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_HEX: begin
					n_q    <= n_q + CNT_W'(1);
					work_q <= work_q >> 4;
					if ((work_q[VALUE_BITS-1:4] == '0) ||
					    (n_q == CNT_W'(itaf_pkg::MAX_DIGITS - 1))) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (neg_q) begin
							m_tdata_q <= itaf_pkg::ASCII_MINUS;
							m_tlast_q <= 1'b0;
							neg_q     <= 1'b0;
						end else begin
							m_tdata_q <= itaf_pkg::digit_char(dig_q[n_m1[IDX_W-1:0]], upper_q);
							m_tlast_q <= (n_q == CNT_W'(1));
							n_q       <= n_m1;
							if (n_q == CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire

[sv/itaf_checker.sv]
// Port-level checker for the formatter and its bind to the top level.
`default_nettype none
`include "integer_to_ascii_formatter_unit_assert.svh"
module itaf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [63:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tlast
);

	logic in_acc;
	logic is_char;
	logic stalled;

	assign in_acc  = s_tvalid && s_tready;
	assign stalled = m_tvalid && !m_tready;
	assign is_char = (m_tdata == itaf_pkg::ASCII_MINUS) ||
	                 ((m_tdata >= itaf_pkg::ASCII_ZERO) && (m_tdata <= itaf_pkg::ASCII_NINE)) ||
	                 ((m_tdata >= itaf_pkg::ASCII_LA) && (m_tdata <= itaf_pkg::ASCII_LF)) ||
	                 ((m_tdata >= itaf_pkg::ASCII_UA) && (m_tdata <= itaf_pkg::ASCII_UF));

	// a new number is never taken while a run is still unfinished
	`ITAF_ASSERT_IMP(a_no_take_mid_run, clk, arst_n, m_tvalid && !m_tlast, !s_tready)
	// taking a number starts conversion at once
	`ITAF_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_acc, !s_tready)
	// only sign, decimal or hex digit characters come out
	`ITAF_ASSERT_IMP(a_char_set, clk, arst_n, m_tvalid, is_char)
	// a stalled character holds
	`ITAF_ASSERT_NXT(a_out_hold, clk, arst_n, stalled,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind integer_to_ascii_formatter_unit itaf_checker u_itaf_checker (.*);
`default_nettype wire
